/* design/mvm_pkg.sv */
// mvm_pkg: shared widths, codes and pipeline types for the matrix-vector multiplier
// no dependencies

package mvm_pkg;

   localparam int IDX_W  = 6;    // row and column index width
   localparam int CNT_W  = 7;    // element count and row/column limits
   localparam int ELEM_W = 16;   // Q4.12 element
   localparam int PROD_W = 32;   // Q8.24 product
   localparam int ACC_W  = 48;   // Q24.24 row sum
   localparam int CSR_IDX_W = 1;

   localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

   localparam logic MODE_MATRIX = 1'b0;
   localparam logic MODE_VECTOR = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE = 1'd1;

   // control carried alongside each multiply-accumulate
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] row;
      logic             first_col;
      logic             last_col;
      logic             last_row;
   } mvm_meta_type;

endpackage

/* design/matrix_vector_multiply_top.sv */
// matrix_vector_multiply_top: sequencer, element counter and config registers
// depends on mvm_pkg, mvm_ram and mvm_mac
//
// Usage:
//   An item is taken when start is high and busy is low. Mode 0 writes one
//   matrix entry at (req_row_index, req_col_index); mode 1 loads one vector
//   element at req_col_index. A mode 1 beat with req_last set kicks off the
//   product of the stored matrix and vector.
//   The final vector element makes the block walk rows_in_use x columns_in_use
//   entries through one shared multiply-accumulate, one entry per cycle, read
//   from a matrix memory and a vector memory with registered read data. One
//   result per row follows once that row's last column is accumulated.
//   busy is high from the cycle after the start beat until the pipeline drains.
//   Results leave on the rsp_ ports for exactly one cycle each, marked by
//   rsp_valid; the receiver cannot stall. rsp_size_error flags a run whose
//   element count differed from columns_in_use; rsp_last_row marks the final row.
//   Registers are written through csr_write_enable / csr_index / csr_write_data
//   while the block is idle; the user must keep to this, the block does not
//   enforce it. Reset sets both limits to 64, clears the element count and
//   stops any run; memory contents are kept and undefined until written.

module matrix_vector_multiply_top
   import mvm_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_mode,
   input  logic [IDX_W-1:0]         req_row_index,
   input  logic [IDX_W-1:0]         req_col_index,
   input  logic signed [ELEM_W-1:0] req_element_value,
   input  logic                     req_last,
   output logic                     rsp_valid,
   output logic [IDX_W-1:0]         rsp_out_row,
   output logic signed [ACC_W-1:0]  rsp_row_result,
   output logic                     rsp_size_error,
   output logic                     rsp_last_row,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CNT_W-1:0]         csr_write_data
);

   localparam int ROW_LIM = (MAX_ROWS < 64) ? MAX_ROWS : 64;
   localparam int COL_LIM = (MAX_COLS < 64) ? MAX_COLS : 64;
   localparam int MAT_DEPTH = ROW_LIM * COL_LIM;
   localparam int MAT_AW = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
   localparam int VEC_AW = (COL_LIM > 1) ? $clog2(COL_LIM) : 1;
   localparam logic [CNT_W-1:0] ROW_LIM_C = CNT_W'(ROW_LIM);
   localparam logic [CNT_W-1:0] COL_LIM_C = CNT_W'(COL_LIM);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] rows_ff, cols_ff;
   logic [CNT_W-1:0] rows_lim, cols_lim;
   logic [CNT_W-1:0] cnt_ff, cnt_inc;
   logic             err_ff;
   logic [IDX_W-1:0] row_ff, row_in;
   logic [IDX_W-1:0] col_ff, col_in;
   logic             accept;
   logic             kick;
   logic             last_col, last_row;
   logic             mat_we, vec_we;
   logic [MAT_AW-1:0] mat_waddr, mat_raddr;
   logic [VEC_AW-1:0] vec_waddr, vec_raddr;
   logic [ELEM_W-1:0] mat_rdata, vec_rdata;
   mvm_meta_type     issue_meta;
   mvm_meta_type     s1_meta_ff;
   logic             mac_busy;

   assign accept = start & ~busy;
   assign kick   = accept & (req_mode == MODE_VECTOR) & req_last;

   // out-of-range register values act as 1 or as the store limit
   always_comb begin
      if (rows_ff == '0) begin
         rows_lim = CNT_W'(1);
      end else if (rows_ff > ROW_LIM_C) begin
         rows_lim = ROW_LIM_C;
      end else begin
         rows_lim = rows_ff;
      end
      if (cols_ff == '0) begin
         cols_lim = CNT_W'(1);
      end else if (cols_ff > COL_LIM_C) begin
         cols_lim = COL_LIM_C;
      end else begin
         cols_lim = cols_ff;
      end
   end

   assign cnt_inc = (cnt_ff == CNT_MAX) ? cnt_ff : cnt_ff + CNT_W'(1);

   // store writes
   assign mat_we = accept & (req_mode == MODE_MATRIX)
                 & ({1'b0, req_row_index} < ROW_LIM_C)
                 & ({1'b0, req_col_index} < COL_LIM_C);
   assign vec_we = accept & (req_mode == MODE_VECTOR)
                 & ({1'b0, req_col_index} < COL_LIM_C);
   assign mat_waddr = MAT_AW'(req_row_index * COL_LIM + req_col_index);
   assign vec_waddr = VEC_AW'(req_col_index);

   // sequencer walks row by row, column by column
   assign last_col  = (({1'b0, col_ff} + CNT_W'(1)) == cols_lim);
   assign last_row  = (({1'b0, row_ff} + CNT_W'(1)) == rows_lim);
   assign mat_raddr = MAT_AW'(row_ff * COL_LIM + col_ff);
   assign vec_raddr = VEC_AW'(col_ff);

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      issue_meta           = '0;
      issue_meta.row       = row_ff;
      issue_meta.first_col = (col_ff == '0);
      issue_meta.last_col  = last_col;
      issue_meta.last_row  = last_row;
      case (state_ff)
         ST_IDLE: begin
            if (kick) begin
               state_in = ST_RUN;
               row_in   = '0;
               col_in   = '0;
            end
         end
         ST_RUN: begin
            issue_meta.valid = 1'b1;
            if (last_col) begin
               col_in = '0;
               if (last_row) begin
                  state_in = ST_IDLE;
               end else begin
                  row_in = row_ff + IDX_W'(1);
               end
            end else begin
               col_in = col_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rows_ff    <= CNT_W'(64);
         cols_ff    <= CNT_W'(64);
         cnt_ff     <= '0;
         s1_meta_ff <= '0;
      end else begin
         state_ff   <= state_in;
         s1_meta_ff <= issue_meta;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ROWS_IN_USE: rows_ff <= csr_write_data;
               CSR_COLS_IN_USE: cols_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
         if (accept && (req_mode == MODE_VECTOR)) begin
            if (req_last) begin
               cnt_ff <= '0;
            end else begin
               cnt_ff <= cnt_inc;
            end
         end
      end
      row_ff <= row_in;
      col_ff <= col_in;
      if (kick) begin
         err_ff <= (cnt_inc != cols_lim);
      end
   end

   mvm_ram #(
      .DEPTH(MAT_DEPTH),
      .AW   (MAT_AW)
   ) u_matrix_ram (
      .clock  (clock),
      .wr_en  (mat_we),
      .wr_addr(mat_waddr),
      .wr_data(req_element_value),
      .rd_addr(mat_raddr),
      .rd_data(mat_rdata)
   );

   mvm_ram #(
      .DEPTH(COL_LIM),
      .AW   (VEC_AW)
   ) u_vector_ram (
      .clock  (clock),
      .wr_en  (vec_we),
      .wr_addr(vec_waddr),
      .wr_data(req_element_value),
      .rd_addr(vec_raddr),
      .rd_data(vec_rdata)
   );

   mvm_mac u_mac (
      .clock         (clock),
      .reset         (reset),
      .mat_data      ($signed(mat_rdata)),
      .vec_data      ($signed(vec_rdata)),
      .meta_in       (s1_meta_ff),
      .pipe_busy     (mac_busy),
      .rsp_valid     (rsp_valid),
      .rsp_out_row   (rsp_out_row),
      .rsp_row_result(rsp_row_result),
      .rsp_last_row  (rsp_last_row)
   );

   assign busy           = (state_ff == ST_RUN) | s1_meta_ff.valid | mac_busy;
   assign rsp_size_error = err_ff;

endmodule

/* design/mvm_ram.sv */
// mvm_ram: single write port, single read port memory with registered read data
// depends on mvm_pkg for the element width

module mvm_ram
   import mvm_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [ELEM_W-1:0] wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [ELEM_W-1:0] rd_data
);

   logic [ELEM_W-1:0] mem [DEPTH];
   logic [ELEM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/mvm_mac.sv */
// mvm_mac: product register, 48-bit accumulator and result register
// depends on mvm_pkg for widths and the mvm_meta_type struct

module mvm_mac
   import mvm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [ELEM_W-1:0] mat_data,
   input  logic signed [ELEM_W-1:0] vec_data,
   input  mvm_meta_type             meta_in,
   output logic                     pipe_busy,
   output logic                     rsp_valid,
   output logic [IDX_W-1:0]         rsp_out_row,
   output logic signed [ACC_W-1:0]  rsp_row_result,
   output logic                     rsp_last_row
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   mvm_meta_type             meta_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic                     rsp_valid_ff;
   logic [IDX_W-1:0]         rsp_row_ff;
   logic signed [ACC_W-1:0]  rsp_result_ff;
   logic                     rsp_last_row_ff;

   assign prod_in = mat_data * vec_data;

   // first column of a row restarts the sum
   always_comb begin
      if (meta_ff.first_col) begin
         acc_in = ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         meta_ff      <= meta_in;
         rsp_valid_ff <= meta_ff.valid & meta_ff.last_col;
      end
      prod_ff <= prod_in;
      if (meta_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (meta_ff.valid && meta_ff.last_col) begin
         rsp_row_ff      <= meta_ff.row;
         rsp_result_ff   <= acc_in;
         rsp_last_row_ff <= meta_ff.last_row;
      end
   end

   assign pipe_busy      = meta_ff.valid;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_row_result = rsp_result_ff;
   assign rsp_last_row   = rsp_last_row_ff;

endmodule
